FILE: rtl/core/lru_block_buffer_policy_assert.svh
// Assertion macros shared by the LRU block buffer RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef LRU_BLOCK_BUFFER_POLICY_ASSERT_SVH
`define LRU_BLOCK_BUFFER_POLICY_ASSERT_SVH

// Checked on every rising edge outside reset.
`define LRUB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define LRUB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/lrub_pkg.sv
// Shared types and constants for the LRU block buffer.
// No dependencies.
`default_nettype none

package lrub_pkg;

  localparam int unsigned DefaultDepth = 8;
  localparam int unsigned MaxResults   = 8;
  localparam int unsigned CfgW         = 4;
  localparam logic [CfgW-1:0] CapReset = 4'd8;

  typedef enum logic [1:0] {
    REQ_GET    = 2'd0,
    REQ_PUT    = 2'd1,
    REQ_COMMIT = 2'd2
  } req_type_e;

  typedef struct packed {
    logic [7:0]  table_id;
    logic [15:0] block_number;
  } lrub_tag_t;

  // Per-cell command, priority load > shift > clear.
  typedef struct packed {
    logic load;
    logic shift;
    logic clr;
  } lrub_cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/lru_block_buffer_policy.sv
// LRU block buffer replacement policy: top level with control and cell chain.
// Depends on lrub_pkg, lrub_cell and lru_block_buffer_policy_assert.svh.
//
// Usage:
//   Requests enter on start with req_type_i, table_id_i and block_number_i;
//   a beat is taken at a rising edge with start high and busy low.
//   Get and put: the request is registered, then in the next cycle the whole
//   cell chain compares the tag in parallel and shifts/loads in the same
//   cycle; the single result is registered onto the result ports at the
//   end of that cycle. busy is high for that one cycle, so the next get or
//   put is taken only once the result is out.
//   Commit: a pointer walks the chain one slot per cycle from the least
//   recent slot. Each dirty slot found is cleared and reported; the latest
//   find is held back until the next find or the end of the walk, so the
//   final one can carry last. The walk ends when the pointer reaches the
//   occupancy or once 8 dirty slots are found. Results of one commit may
//   come with idle gaps.
//   Each result beat is valid for exactly one cycle on result_valid_o; the
//   receiver cannot stall, so nothing downstream holds the block up.
//   lookup_count_o and hit_count_o show the live counters.
//   Config: cfg_valid_i/cfg_data_i write capacity, always ready; write it
//   only while idle. Capacity 0 behaves as 1, above DEPTH as DEPTH.
//   Reset: empty buffer, all dirty marks clear, counters zero, capacity 8.
`default_nettype none

module lru_block_buffer_policy import lrub_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // request channel
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       req_type_i,
  input  logic [7:0]       table_id_i,
  input  logic [15:0]      block_number_i,
  // capacity register write
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CfgW-1:0]  cfg_data_i,
  // result channel
  output logic             result_valid_o,
  output logic             hit_o,
  output logic [2:0]       slot_o,
  output logic             writeback_valid_o,
  output logic [7:0]       writeback_table_o,
  output logic [15:0]      writeback_block_o,
  output logic [31:0]      lookup_count_o,
  output logic [31:0]      hit_count_o,
  output logic             last_o
);

  localparam int unsigned OW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (OW > CfgW) ? OW : CfgW;
  localparam int unsigned FW = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_e;

  state_e          state_q;
  req_type_e       req_q;
  lrub_tag_t       key_q;
  logic [CfgW-1:0] cap_q;
  logic [OW-1:0]   occ_q;
  logic [31:0]     lookups_q;
  logic [31:0]     hits_q;
  logic [OW-1:0]   ptr_q;
  logic [FW-1:0]   found_q;
  logic            pend_v_q;
  logic [OW-1:0]   pend_slot_q;
  lrub_tag_t       pend_tag_q;

  logic            res_valid_q;
  logic            res_hit_q;
  logic [2:0]      res_slot_q;
  logic            res_wbv_q;
  lrub_tag_t       res_wb_q;
  logic            res_last_q;

  lrub_tag_t       cell_tag   [DEPTH];
  logic            cell_dirty [DEPTH];
  logic            cell_match [DEPTH];
  lrub_cell_ctrl_t cell_ctrl  [DEPTH];

  logic [CW-1:0]   cap_eff;
  logic            full;
  logic            hit_any;
  logic [OW-1:0]   hit_idx;
  lrub_tag_t       scan_tag;
  logic            scan_dirty;
  logic            put_go;
  logic            do_shift;
  logic [OW-1:0]   shift_src;
  logic [OW-1:0]   new_pos;
  logic            scan_end;
  logic            scan_step;

  function automatic logic [2:0] slot3(input logic [OW-1:0] v);
    logic [OW+2:0] t;
    t = {3'b000, v};
    return t[2:0];
  endfunction

  // ---------------------------------------------------------------------
  // Cell chain: cell g takes its neighbor g+1 on a shift toward slot 0
  // ---------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    lrub_tag_t nbr_tag;
    logic      nbr_dirty;

    if (g == DEPTH - 1) begin : g_tail
      assign nbr_tag   = '0;
      assign nbr_dirty = 1'b0;
    end else begin : g_mid
      assign nbr_tag   = cell_tag[g+1];
      assign nbr_dirty = cell_dirty[g+1];
    end

    always_comb begin
      cell_ctrl[g].load  = put_go && (OW'(g) == new_pos);
      cell_ctrl[g].shift = put_go && do_shift && (OW'(g) >= shift_src) && (OW'(g) < new_pos);
      cell_ctrl[g].clr   = scan_step && (ptr_q == OW'(g));
    end

    lrub_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl[g]),
      .req_tag_i   (key_q),
      .nbr_tag_i   (nbr_tag),
      .nbr_dirty_i (nbr_dirty),
      .tag_o       (cell_tag[g]),
      .dirty_o     (cell_dirty[g]),
      .match_o     (cell_match[g])
    );
  end

  // ---------------------------------------------------------------------
  // Lookup result, capacity clamp, scan read-out
  // ---------------------------------------------------------------------
  always_comb begin
    cap_eff = CW'(cap_q);
    if (cap_eff == '0) begin
      cap_eff = CW'(1);
    end else if (cap_eff > CW'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end
  end

  assign full = (CW'(occ_q) >= cap_eff);

  // tags in the live region are unique, so an OR of the hit indexes encodes
  always_comb begin
    hit_any    = 1'b0;
    hit_idx    = '0;
    scan_tag   = '0;
    scan_dirty = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_match[i] && (OW'(i) < occ_q)) begin
        hit_any = 1'b1;
        hit_idx = hit_idx | OW'(i);
      end
      if (ptr_q == OW'(i)) begin
        scan_tag   = scan_tag | cell_tag[i];
        scan_dirty = scan_dirty | cell_dirty[i];
      end
    end
  end

  assign put_go    = (state_q == ST_EXEC) && (req_q == REQ_PUT);
  assign do_shift  = hit_any || full;
  assign shift_src = hit_any ? hit_idx : '0;
  assign new_pos   = do_shift ? (occ_q - OW'(1)) : occ_q;
  assign scan_end  = (ptr_q == occ_q) || (found_q == FW'(MaxResults));
  assign scan_step = (state_q == ST_SCAN) && !scan_end;

  // ---------------------------------------------------------------------
  // Control and result registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      req_q       <= REQ_GET;
      key_q       <= '0;
      cap_q       <= CapReset;
      occ_q       <= '0;
      lookups_q   <= '0;
      hits_q      <= '0;
      ptr_q       <= '0;
      found_q     <= '0;
      pend_v_q    <= 1'b0;
      pend_slot_q <= '0;
      pend_tag_q  <= '0;
      res_valid_q <= 1'b0;
      res_hit_q   <= 1'b0;
      res_slot_q  <= '0;
      res_wbv_q   <= 1'b0;
      res_wb_q    <= '0;
      res_last_q  <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;

      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            req_q   <= req_type_e'(req_type_i);
            key_q   <= '{table_id: table_id_i, block_number: block_number_i};
            state_q <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          res_valid_q <= 1'b1;
          res_last_q  <= 1'b1;
          res_hit_q   <= 1'b0;
          res_slot_q  <= '0;
          res_wbv_q   <= 1'b0;
          res_wb_q    <= '0;
          state_q     <= ST_IDLE;
          unique case (req_q)
            REQ_GET: begin
              lookups_q <= lookups_q + 32'd1;
              if (hit_any) begin
                hits_q     <= hits_q + 32'd1;
                res_hit_q  <= 1'b1;
                res_slot_q <= slot3(hit_idx);
              end
            end
            REQ_PUT: begin
              res_hit_q <= hit_any;
              if (hit_any) begin
                res_slot_q <= slot3(occ_q - OW'(1));
              end else if (!full) begin
                res_slot_q <= slot3(occ_q);
                occ_q      <= occ_q + OW'(1);
              end else begin
                // evict least recent, written back dirty or not
                res_slot_q <= slot3(occ_q - OW'(1));
                res_wbv_q  <= 1'b1;
                res_wb_q   <= cell_tag[0];
              end
            end
            REQ_COMMIT: begin
              res_valid_q <= 1'b0;
              ptr_q       <= '0;
              found_q     <= '0;
              pend_v_q    <= 1'b0;
              state_q     <= ST_SCAN;
            end
            default: begin
              // reserved request code: empty result
            end
          endcase
        end

        ST_SCAN: begin
          if (scan_end) begin
            res_valid_q <= 1'b1;
            res_last_q  <= 1'b1;
            res_hit_q   <= 1'b0;
            res_slot_q  <= pend_v_q ? slot3(pend_slot_q) : 3'd0;
            res_wbv_q   <= pend_v_q;
            res_wb_q    <= pend_v_q ? pend_tag_q : '0;
            pend_v_q    <= 1'b0;
            state_q     <= ST_IDLE;
          end else begin
            ptr_q <= ptr_q + OW'(1);
            if (scan_dirty) begin
              // hold the newest find so the final beat can carry last
              if (pend_v_q) begin
                res_valid_q <= 1'b1;
                res_last_q  <= 1'b0;
                res_hit_q   <= 1'b0;
                res_slot_q  <= slot3(pend_slot_q);
                res_wbv_q   <= 1'b1;
                res_wb_q    <= pend_tag_q;
              end
              pend_v_q    <= 1'b1;
              pend_slot_q <= ptr_q;
              pend_tag_q  <= scan_tag;
              found_q     <= found_q + FW'(1);
            end
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy              = (state_q != ST_IDLE);
  assign cfg_ready_o       = 1'b1;
  assign result_valid_o    = res_valid_q;
  assign hit_o             = res_hit_q;
  assign slot_o            = res_slot_q;
  assign writeback_valid_o = res_wbv_q;
  assign writeback_table_o = res_wb_q.table_id;
  assign writeback_block_o = res_wb_q.block_number;
  assign lookup_count_o    = lookups_q;
  assign hit_count_o       = hits_q;
  assign last_o            = res_last_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `include "lru_block_buffer_policy_assert.svh"

  `LRUB_ASSERT(a_accept_to_exec, (start && !busy) |=> (state_q == ST_EXEC), "accept did not start")
  `LRUB_ASSERT(a_occ_bound, occ_q <= OW'(DEPTH), "occupancy above depth")
  `LRUB_ASSERT(a_occ_step, 1'b1 |=> ((occ_q == $past(occ_q)) || (occ_q == $past(occ_q) + OW'(1))), "occupancy jumped")
  `LRUB_ASSERT(a_mid_beat_busy, (res_valid_q && !res_last_q) |-> busy, "non-final beat while idle")
  `LRUB_ASSERT(a_hits_le_lookups, (hits_q != $past(hits_q)) |-> (lookups_q != $past(lookups_q)), "hit without lookup")

endmodule

`default_nettype wire

FILE: rtl/core/lrub_cell.sv
// One slot of the LRU tag chain: tag, dirty mark and tag compare.
// Depends on lrub_pkg.
`default_nettype none

module lrub_cell import lrub_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lrub_cell_ctrl_t ctrl_i,
  input  lrub_tag_t       req_tag_i,
  input  lrub_tag_t       nbr_tag_i,
  input  logic            nbr_dirty_i,
  output lrub_tag_t       tag_o,
  output logic            dirty_o,
  output logic            match_o
);

  lrub_tag_t tag_q, tag_d;
  logic      dirty_q, dirty_d;

  always_comb begin
    tag_d   = tag_q;
    dirty_d = dirty_q;
    priority if (ctrl_i.load) begin
      tag_d   = req_tag_i;
      dirty_d = 1'b1;
    end else if (ctrl_i.shift) begin
      tag_d   = nbr_tag_i;
      dirty_d = nbr_dirty_i;
    end else if (ctrl_i.clr) begin
      dirty_d = 1'b0;
    end
  end

  // tag storage is undefined until written, no reset
  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_q <= 1'b0;
    end else begin
      dirty_q <= dirty_d;
    end
  end

  assign tag_o   = tag_q;
  assign dirty_o = dirty_q;
  assign match_o = (tag_q == req_tag_i);

endmodule

`default_nettype wire

FILE: tb/lru_block_buffer_policy_test.sv
// Self-checking testbench for lru_block_buffer_policy: directed and random
// get/put/commit traffic, checked against an in-bench model of the tag buffer.
// Depends on lrub_pkg and the lru_block_buffer_policy RTL.
`default_nettype none

module lru_block_buffer_policy_test;
  import lrub_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = DefaultDepth;
  // Type 3 is not in req_type_e; the block must answer it with an empty beat.
  localparam logic [1:0] REQ_RESERVED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Extra idle margin after the block goes idle, sized from DEPTH.
  localparam int unsigned SETTLE_CYCLES = DEPTH + 4;
  localparam int unsigned POOL_SIZE = 12;

  // One result beat as the block presents it.
  typedef struct packed {
    logic        hit;
    logic [2:0]  slot;
    logic        wb_valid;
    logic [7:0]  wb_table;
    logic [15:0] wb_block;
    logic [31:0] lookups;
    logic [31:0] hits;
    logic        last;
  } buf_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       req_type_i = '0;
  logic [7:0]       table_id_i = '0;
  logic [15:0]      block_number_i = '0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CfgW-1:0]  cfg_data_i = '0;
  logic             result_valid_o;
  logic             hit_o;
  logic [2:0]       slot_o;
  logic             writeback_valid_o;
  logic [7:0]       writeback_table_o;
  logic [15:0]      writeback_block_o;
  logic [31:0]      lookup_count_o;
  logic [31:0]      hit_count_o;
  logic             last_o;

  lru_block_buffer_policy #(.DEPTH(DEPTH)) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .req_type_i        (req_type_i),
    .table_id_i        (table_id_i),
    .block_number_i    (block_number_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .result_valid_o    (result_valid_o),
    .hit_o             (hit_o),
    .slot_o            (slot_o),
    .writeback_valid_o (writeback_valid_o),
    .writeback_table_o (writeback_table_o),
    .writeback_block_o (writeback_block_o),
    .lookup_count_o    (lookup_count_o),
    .hit_count_o       (hit_count_o),
    .last_o            (last_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Buffer model: tags in LRU order, slot 0 least recent.
  // ---------------------------------------------------------------------
  logic [7:0]  tag_tbl   [DEPTH];
  logic [15:0] tag_blk   [DEPTH];
  logic        tag_dirty [DEPTH];
  int          fill;
  logic [31:0] lookup_total;
  logic [31:0] hit_total;
  logic [3:0]  capacity_reg;

  // Results owed by the block, oldest first.
  buf_result_t pending_results[$];

  int mismatches;
  int send_idle_pct;
  int unsigned cycles;

  logic [7:0]  pool_tbl [POOL_SIZE];
  logic [15:0] pool_blk [POOL_SIZE];

  // Queue one expected beat behind the ones already owed.
  function automatic void owe_result(input buf_result_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic int lru_find(input logic [7:0] t, input logic [15:0] b);
    for (int i = 0; i < fill; i++)
      if (tag_tbl[i] == t && tag_blk[i] == b) return i;
    return -1;
  endfunction

  // Drop entry i, sliding the more recent ones down.
  function automatic void lru_remove(input int i);
    for (int j = i; j + 1 < fill; j++) begin
      tag_tbl[j]   = tag_tbl[j + 1];
      tag_blk[j]   = tag_blk[j + 1];
      tag_dirty[j] = tag_dirty[j + 1];
    end
    if (fill > 0) fill--;
  endfunction

  function automatic void lru_append(input logic [7:0] t, input logic [15:0] b);
    if (fill < DEPTH) begin
      tag_tbl[fill]   = t;
      tag_blk[fill]   = b;
      tag_dirty[fill] = 1'b1;
      fill++;
    end
  endfunction

  // Update the model for one accepted beat and queue the results it owes.
  function automatic void apply_request(input logic [1:0] rt, input logic [7:0] t,
                                        input logic [15:0] b);
    int cap;
    int idx;
    int n_dirty;
    int k;
    buf_result_t r;
    cap = (capacity_reg == 0) ? 1 : (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
    r = '0;
    r.last = 1'b1;
    case (rt)
      REQ_GET: begin
        lookup_total++;
        idx = lru_find(t, b);
        if (idx >= 0) begin
          hit_total++;
          r.hit  = 1'b1;
          r.slot = 3'(idx);
        end
        r.lookups = lookup_total;
        r.hits    = hit_total;
        owe_result(r);
      end
      REQ_PUT: begin
        idx = lru_find(t, b);
        if (idx >= 0) begin
          // refresh: move to most recent
          lru_remove(idx);
          lru_append(t, b);
          r.hit = 1'b1;
        end else if (fill < cap) begin
          lru_append(t, b);
        end else begin
          // full (or capacity lowered): evict the oldest, dirty or not
          r.wb_valid = 1'b1;
          r.wb_table = tag_tbl[0];
          r.wb_block = tag_blk[0];
          lru_remove(0);
          lru_append(t, b);
        end
        r.slot    = 3'(fill - 1);
        r.lookups = lookup_total;
        r.hits    = hit_total;
        owe_result(r);
      end
      REQ_COMMIT: begin
        n_dirty = 0;
        for (int i = 0; i < fill; i++)
          if (tag_dirty[i] && n_dirty < MaxResults) n_dirty++;
        r.lookups = lookup_total;
        r.hits    = hit_total;
        if (n_dirty == 0) begin
          owe_result(r);
        end else begin
          k = 0;
          for (int i = 0; i < fill && k < n_dirty; i++) begin
            if (tag_dirty[i]) begin
              tag_dirty[i] = 1'b0;
              r.slot     = 3'(i);
              r.wb_valid = 1'b1;
              r.wb_table = tag_tbl[i];
              r.wb_block = tag_blk[i];
              r.last     = (k == n_dirty - 1);
              owe_result(r);
              k++;
            end
          end
        end
      end
      default: begin
        r.lookups = lookup_total;
        r.hits    = hit_total;
        owe_result(r);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  // Present one request and hold it until the block takes the beat. start is
  // left high so a back-to-back request needs no second assignment this step.
  task automatic send_req(input logic [1:0] rt, input logic [7:0] t,
                          input logic [15:0] b);
    start          <= 1'b1;
    req_type_i     <= rt;
    table_id_i     <= t;
    block_number_i <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    apply_request(rt, t, b);
  endtask

  // Random sender idle cycles between beats.
  task automatic sender_gap();
    if ($urandom_range(0, 99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk_i);
    end
  endtask

  task automatic send_gapped(input logic [1:0] rt, input logic [7:0] t,
                             input logic [15:0] b);
    send_req(rt, t, b);
    sender_gap();
  endtask

  // Bring the block to idle: all results in, commit walk finished.
  task automatic settle_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [3:0] v);
    settle_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    capacity_reg = v;
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Result checking: every strobe beat against the oldest expectation.
  // ---------------------------------------------------------------------
  function automatic string fmt_result(input buf_result_t r);
    return $sformatf("hit=%0d slot=%0d wb=%0d tbl=%0h blk=%0h lookups=%0d hits=%0d last=%0d",
                     r.hit, r.slot, r.wb_valid, r.wb_table, r.wb_block,
                     r.lookups, r.hits, r.last);
  endfunction

  always @(posedge clk_i) begin : result_check
    buf_result_t want;
    buf_result_t got;
    if (rst_ni && result_valid_o) begin
      got.hit      = hit_o;
      got.slot     = slot_o;
      got.wb_valid = writeback_valid_o;
      got.wb_table = writeback_table_o;
      got.wb_block = writeback_block_o;
      got.lookups  = lookup_count_o;
      got.hits     = hit_count_o;
      got.last     = last_o;
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] result beat with nothing expected: %s", $realtime,
                   fmt_result(got));
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("[%0t] result mismatch", $realtime);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(got));
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("lru_block_buffer_policy test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Empty-buffer cases, hits, refresh, commit, eviction at reset capacity.
  task automatic test_basic_ops();
    send_gapped(REQ_GET,      8'h00, 16'h0000);  // miss on empty buffer
    send_gapped(REQ_COMMIT,   8'h00, 16'h0000);  // nothing dirty
    send_gapped(REQ_RESERVED, 8'hff, 16'hffff);  // no-op type
    send_gapped(REQ_PUT,      8'hff, 16'hffff);
    send_gapped(REQ_PUT,      8'h00, 16'h0000);
    send_gapped(REQ_PUT,      8'h00, 16'hffff);
    send_gapped(REQ_GET,      8'hff, 16'hffff);  // hit, get keeps recency
    send_gapped(REQ_PUT,      8'hff, 16'hffff);  // refresh to most recent
    send_gapped(REQ_GET,      8'h00, 16'h0000);  // now least recent
    send_gapped(REQ_GET,      8'hff, 16'h0000);  // near miss on table match
    send_gapped(REQ_COMMIT,   8'h00, 16'h0000);  // three write-backs
    send_gapped(REQ_COMMIT,   8'h00, 16'h0000);  // all clean again
    for (int i = 0; i < 5; i++)
      send_gapped(REQ_PUT, 8'(8'h10 + i), 16'(16'h1234 * (i + 1)));
    // full: evicts the clean oldest entry
    send_gapped(REQ_PUT,    8'haa, 16'h5555);
    send_gapped(REQ_COMMIT, 8'h00, 16'h0000);
  endtask

  // Capacity extremes and shrinking below the current fill.
  task automatic test_capacity_limits();
    write_capacity(4'd3);                     // below fill: evict, no growth
    send_gapped(REQ_PUT, 8'h55, 16'haaaa);
    write_capacity(4'd0);                     // acts as 1
    send_gapped(REQ_PUT, 8'h5a, 16'h00ff);
    send_gapped(REQ_PUT, 8'h5a, 16'h00ff);    // hit still refreshes
    write_capacity(4'd15);                    // acts as DEPTH
    send_gapped(REQ_PUT, 8'ha5, 16'hff00);
    write_capacity(4'd1);
    send_gapped(REQ_PUT, 8'h01, 16'h0001);
    send_gapped(REQ_COMMIT, 8'h00, 16'h0000);
  endtask

  // Random traffic over a small tag pool so hits and evictions are common.
  task automatic test_random_phase(input int idle_pct, input logic [3:0] cap,
                                   input int count);
    int pick;
    int sel;
    logic [1:0]  rt;
    logic [7:0]  t;
    logic [15:0] b;
    send_idle_pct = idle_pct;
    write_capacity(cap);
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_tbl[i] = 8'($urandom);
      pool_blk[i] = 16'($urandom);
    end
    pool_tbl[0] = 8'hff;
    pool_blk[0] = 16'hffff;
    pool_tbl[1] = 8'h00;
    pool_blk[1] = 16'h0000;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      rt = REQ_GET;
      else if (pick < 85) rt = REQ_PUT;
      else if (pick < 96) rt = REQ_COMMIT;
      else                rt = REQ_RESERVED;
      if ($urandom_range(0, 99) < 75) begin
        sel = $urandom_range(0, POOL_SIZE - 1);
        t = pool_tbl[sel];
        b = pool_blk[sel];
      end else begin
        t = 8'($urandom);
        b = 16'($urandom);
      end
      send_gapped(rt, t, b);
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) tag_dirty[i] = 1'b0;
    fill          = 0;
    lookup_total  = '0;
    hit_total     = '0;
    capacity_reg  = CapReset;
    mismatches    = 0;
    cycles        = 0;
    send_idle_pct = 38;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_ops();
    test_capacity_limits();
    // sender idles often, then very often, then never
    test_random_phase(38, 4'd2, 24);
    test_random_phase(83, 4'd15, 24);
    test_random_phase(0, 4'($urandom_range(0, 15)), 24);
    test_random_phase(0, 4'd8, 24);

    settle_idle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("lru_block_buffer_policy test passed");
    end else begin
      $display("lru_block_buffer_policy test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
